### src/csfp_pkg.sv
// ----------------------------------------------------------------------------
// csfp_pkg
// Shared types, codes and helpers for the channel sample frame packer.
// ----------------------------------------------------------------------------
package csfp_pkg;

    // fixed field geometry
    localparam int HEADER_BYTES   = 3;
    localparam int MAX_CHANNELS   = 8;
    localparam int VALUE_BITS     = 32;
    localparam int BYTE_BITS      = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;

    // header byte positions within a frame
    localparam int HDR_REPORT_ID   = 0;
    localparam int HDR_CLIENT_CODE = 1;
    localparam int HDR_SET_COUNT   = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_CHANNEL_MASK   = 3'd0;
    localparam cfg_index_t REG_WIDTH_MODE     = 3'd1;
    localparam cfg_index_t REG_STREAMING_MODE = 3'd2;
    localparam cfg_index_t REG_CLIENT_CODE    = 3'd3;
    localparam cfg_index_t REG_REPORT_ID      = 3'd4;

    // width mode after reset: two bytes per value
    localparam logic [1:0] WIDTH_MODE_RESET = 2'd1;

    // item opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_PACK,
        CS_DECIDE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_SEND
    } emit_state_t;

    // one payload byte from the serialiser
    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] data;
    } pack_byte_t;

    // controls from the sequencer to the frame store
    typedef struct packed {
        logic count_set;
        logic start_emit;
    } store_ctrl_t;

    // bytes per channel value; only bit 1 decides four bytes
    function automatic logic [2:0] value_bytes(input logic [1:0] mode);
        logic [2:0] n;
        if (mode[1])
            n = 3'd4;
        else if (mode[0])
            n = 3'd2;
        else
            n = 3'd1;
        return n;
    endfunction

endpackage

### src/csfp_in_if.sv
// ----------------------------------------------------------------------------
// csfp_in_if
// Input channel: one opcode and eight channel values per item.
// ----------------------------------------------------------------------------
interface csfp_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_0;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_1;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_2;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_3;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_4;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_5;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_6;
    logic [csfp_pkg::VALUE_BITS-1:0]   chan_value_7;

    modport source (
        output valid, opcode,
        output chan_value_0, chan_value_1, chan_value_2, chan_value_3,
        output chan_value_4, chan_value_5, chan_value_6, chan_value_7,
        input  ready
    );

    modport sink (
        input  valid, opcode,
        input  chan_value_0, chan_value_1, chan_value_2, chan_value_3,
        input  chan_value_4, chan_value_5, chan_value_6, chan_value_7,
        output ready
    );
endinterface

### src/csfp_out_if.sv
// ----------------------------------------------------------------------------
// csfp_out_if
// Output channel: one frame byte per item, with a last-byte mark.
// ----------------------------------------------------------------------------
interface csfp_out_if;
    logic                             valid;
    logic                             ready;
    logic [csfp_pkg::BYTE_BITS-1:0]   frame_byte;
    logic                             frame_last;

    modport source (
        output valid, frame_byte, frame_last,
        input  ready
    );

    modport sink (
        input  valid, frame_byte, frame_last,
        output ready
    );
endinterface

### src/csfp_byte_serialiser.sv
// ----------------------------------------------------------------------------
// csfp_byte_serialiser
// Walks the captured channel values through a shift line and sends the
// enabled ones out big-endian, one byte per cycle.
// ----------------------------------------------------------------------------
module csfp_byte_serialiser #(
    parameter int CHANNELS = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         start,
    input  logic [CHANNELS-1:0][csfp_pkg::VALUE_BITS-1:0] values,
    input  logic [CHANNELS-1:0]                          mask,
    input  logic [1:0]                                   width_mode,
    output csfp_pkg::pack_byte_t                         byte_out,
    output logic                                         done
);

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int VB    = csfp_pkg::VALUE_BITS;
    localparam int BB    = csfp_pkg::BYTE_BITS;

    logic [VB-1:0]       chan_reg [CHANNELS];
    logic [VB-1:0]       chan_next [CHANNELS];
    logic [CHANNELS-1:0] mask_reg, mask_next;
    logic [VB-1:0]       shift_reg, shift_next;
    logic [2:0]          byte_cnt_reg, byte_cnt_next;
    logic [CNT_W-1:0]    ch_cnt_reg, ch_cnt_next;
    logic                busy_reg, busy_next;
    logic [VB-1:0]       aligned;

    // head channel value moved so that its first byte sits at the top
    always_comb
    begin
        if (width_mode[1])
            aligned = chan_reg[0];
        else if (width_mode[0])
            aligned = {chan_reg[0][15:0], 16'd0};
        else
            aligned = {chan_reg[0][7:0], 24'd0};
    end

    // channel walk and byte shifting
    always_comb
    begin
        chan_next     = chan_reg;
        mask_next     = mask_reg;
        shift_next    = shift_reg;
        byte_cnt_next = byte_cnt_reg;
        ch_cnt_next   = ch_cnt_reg;
        busy_next     = busy_reg;
        byte_out      = '0;
        done          = 1'b0;

        if (start)
        begin
            for (int i = 0; i < CHANNELS; i++)
                chan_next[i] = values[i];
            mask_next     = mask;
            ch_cnt_next   = CNT_W'(CHANNELS);
            byte_cnt_next = 3'd0;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            if (byte_cnt_reg != 3'd0)
            begin
                // remaining bytes of the current value
                byte_out.valid = 1'b1;
                byte_out.data  = shift_reg[VB-1 -: BB];
                shift_next     = shift_reg << BB;
                byte_cnt_next  = byte_cnt_reg - 3'd1;
            end
            else if (ch_cnt_reg == '0)
            begin
                done      = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                // next channel: send its first byte now if enabled
                if (mask_reg[0])
                begin
                    byte_out.valid = 1'b1;
                    byte_out.data  = aligned[VB-1 -: BB];
                    shift_next     = aligned << BB;
                    byte_cnt_next  = csfp_pkg::value_bytes(width_mode) - 3'd1;
                end
                for (int i = 0; i < CHANNELS - 1; i++)
                    chan_next[i] = chan_reg[i + 1];
                mask_next   = mask_reg >> 1;
                ch_cnt_next = ch_cnt_reg - CNT_W'(1);
            end
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        chan_reg  <= chan_next;
        shift_reg <= shift_next;
        mask_reg  <= mask_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= 3'd0;
            ch_cnt_reg   <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            byte_cnt_reg <= byte_cnt_next;
            ch_cnt_reg   <= ch_cnt_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

### src/csfp_frame_store.sv
// ----------------------------------------------------------------------------
// csfp_frame_store
// Payload memory with fill offset and set count, and the frame sender that
// streams header and payload bytes through an output register.
// ----------------------------------------------------------------------------
module csfp_frame_store #(
    parameter int FRAME_BYTES = 64
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  csfp_pkg::pack_byte_t                                    wr_byte,
    input  csfp_pkg::store_ctrl_t                                   ctrl,
    input  logic [csfp_pkg::BYTE_BITS-1:0]                          report_id,
    input  logic [csfp_pkg::BYTE_BITS-1:0]                          client_code,
    output logic [$clog2(FRAME_BYTES-csfp_pkg::HEADER_BYTES+1)-1:0] fill,
    output logic                                                    busy,
    csfp_out_if.source                                              frames
);

    localparam int HDR    = csfp_pkg::HEADER_BYTES;
    localparam int CAP    = FRAME_BYTES - HDR;
    localparam int ADDR_W = $clog2(CAP);
    localparam int FILL_W = $clog2(CAP + 1);
    localparam int K_W    = $clog2(FRAME_BYTES);
    localparam int T_W    = K_W + 1;
    localparam int BB     = csfp_pkg::BYTE_BITS;

    logic [BB-1:0]           mem [CAP];
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [BB-1:0]           set_count_reg, set_count_next;
    logic [K_W-1:0]          k_reg, k_next;
    csfp_pkg::emit_state_t   em_state_reg, em_state_next;
    logic [BB-1:0]           rd_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [BB-1:0]           out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;
    logic                    wr_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    last;
    logic [BB-1:0]           send_byte;

    // bytes past the payload capacity are dropped
    assign wr_en = wr_byte.valid && (fill_reg < FILL_W'(CAP));

    // payload read address for the current frame byte
    always_comb
    begin
        if (k_reg >= K_W'(HDR))
            rd_addr = ADDR_W'(k_reg - K_W'(HDR));
        else
            rd_addr = '0;
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[fill_reg[ADDR_W-1:0]] <= wr_byte.data;
        rd_data_reg <= mem[rd_addr];
    end

    assign last = (T_W'(k_reg) + T_W'(1)) == (T_W'(HDR) + T_W'(fill_reg));

    // header bytes first, then payload
    always_comb
    begin
        if (k_reg == K_W'(csfp_pkg::HDR_REPORT_ID))
            send_byte = report_id;
        else if (k_reg == K_W'(csfp_pkg::HDR_CLIENT_CODE))
            send_byte = client_code;
        else if (k_reg == K_W'(csfp_pkg::HDR_SET_COUNT))
            send_byte = set_count_reg;
        else
            send_byte = rd_data_reg;
    end

    // frame sender and counters
    always_comb
    begin
        fill_next      = fill_reg;
        set_count_next = set_count_reg;
        k_next         = k_reg;
        em_state_next  = em_state_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (wr_en)
            fill_next = fill_reg + FILL_W'(1);
        if (ctrl.count_set)
            set_count_next = set_count_reg + BB'(1);
        if (out_valid_reg && frames.ready)
            out_valid_next = 1'b0;

        case (em_state_reg)
            csfp_pkg::EM_IDLE:
            begin
                if (ctrl.start_emit)
                begin
                    k_next        = '0;
                    em_state_next = csfp_pkg::EM_READ;
                end
            end
            csfp_pkg::EM_READ:
            begin
                em_state_next = csfp_pkg::EM_SEND;
            end
            csfp_pkg::EM_SEND:
            begin
                if (!out_valid_reg || frames.ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = send_byte;
                    out_last_next  = last;
                    if (last)
                    begin
                        fill_next      = '0;
                        set_count_next = '0;
                        em_state_next  = csfp_pkg::EM_IDLE;
                    end
                    else
                    begin
                        k_next        = k_reg + K_W'(1);
                        em_state_next = csfp_pkg::EM_READ;
                    end
                end
            end
            default:
            begin
                em_state_next = csfp_pkg::EM_IDLE;
            end
        endcase
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        k_reg        <= k_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            set_count_reg <= '0;
            em_state_reg  <= csfp_pkg::EM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            set_count_reg <= set_count_next;
            em_state_reg  <= em_state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign frames.valid      = out_valid_reg;
    assign frames.frame_byte = out_byte_reg;
    assign frames.frame_last = out_last_reg;
    assign fill              = fill_reg;
    assign busy              = (em_state_reg != csfp_pkg::EM_IDLE);

endmodule

### src/channel_sample_frame_packer.sv
// ----------------------------------------------------------------------------
// channel_sample_frame_packer
// Packs masked channel values into byte frames with a three-byte header.
// ----------------------------------------------------------------------------
// Usage: samples carries one item per sample set (opcode append) or a flush
// request (opcode flush). frames carries one item per frame byte: report id,
// application code, set count, then the payload bytes, frame_last on the
// final byte. The cfg_* port writes one register per cycle; the user must write
// it only while idle, which the block itself does not enforce. Sequence: an
// append walks the channels through a shift line, one channel at a time; an
// enabled channel sends as many bytes as its byte width, and the set ends in
// a decision state. The frame sender reads the payload memory through its
// single registered read port and alternates a read state and a send state
// for each byte. A flush of an empty frame sends no frame.
// samples.ready is low while a set is packed or a frame is sent.
// Reset clears the registers to their defaults and empties the frame; the
// payload memory keeps its contents. A stalled receiver holds the byte in
// the output register and the sender waits; the next item is taken as soon
// as the sender has handed over the last byte.
// ----------------------------------------------------------------------------
module channel_sample_frame_packer #(
    parameter int FRAME_BYTES = 64,
    parameter int CHANNELS    = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    csfp_in_if.sink                               samples,
    csfp_out_if.source                            frames,
    input  logic                                  cfg_wr_en,
    input  logic [csfp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [csfp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int CAP    = FRAME_BYTES - csfp_pkg::HEADER_BYTES;
    localparam int FILL_W = $clog2(CAP + 1);
    localparam int EN_W   = $clog2(CHANNELS + 1);
    localparam int NEED_W = $clog2(4 * CHANNELS + 1);
    localparam int SUM_W  = ((FILL_W > NEED_W) ? FILL_W : NEED_W) + 1;
    localparam int VB     = csfp_pkg::VALUE_BITS;
    localparam int BB     = csfp_pkg::BYTE_BITS;

    logic [BB-1:0]               mask_reg, mask_next;
    logic [1:0]                  width_reg, width_next;
    logic                        stream_reg, stream_next;
    logic [BB-1:0]               client_code_reg, client_code_next;
    logic [BB-1:0]               report_id_reg, report_id_next;
    csfp_pkg::ctrl_state_t       state_reg, state_next;

    logic [csfp_pkg::MAX_CHANNELS-1:0][VB-1:0] all_values;
    logic                        accept;
    logic                        ser_start;
    logic                        ser_done;
    csfp_pkg::pack_byte_t        ser_byte;
    csfp_pkg::store_ctrl_t       ctrl;
    logic [FILL_W-1:0]           fill;
    logic                        store_busy;
    logic [EN_W-1:0]             en_count;
    logic [NEED_W-1:0]           need;
    logic                        full;

    // configuration registers
    always_comb
    begin
        mask_next        = mask_reg;
        width_next       = width_reg;
        stream_next      = stream_reg;
        client_code_next = client_code_reg;
        report_id_next   = report_id_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                csfp_pkg::REG_CHANNEL_MASK:   mask_next        = cfg_data;
                csfp_pkg::REG_WIDTH_MODE:     width_next       = cfg_data[1:0];
                csfp_pkg::REG_STREAMING_MODE: stream_next      = cfg_data[0];
                csfp_pkg::REG_CLIENT_CODE:    client_code_next = cfg_data;
                csfp_pkg::REG_REPORT_ID:      report_id_next   = cfg_data;
                default:                      mask_next        = mask_reg;
            endcase
        end
    end

    // channel values in index order
    assign all_values[0] = samples.chan_value_0;
    assign all_values[1] = samples.chan_value_1;
    assign all_values[2] = samples.chan_value_2;
    assign all_values[3] = samples.chan_value_3;
    assign all_values[4] = samples.chan_value_4;
    assign all_values[5] = samples.chan_value_5;
    assign all_values[6] = samples.chan_value_6;
    assign all_values[7] = samples.chan_value_7;

    assign samples.ready = (state_reg == csfp_pkg::CS_IDLE) && !store_busy;
    assign accept        = samples.valid && samples.ready;

    // room check for one more set of the current size
    always_comb
    begin
        en_count = '0;
        for (int i = 0; i < CHANNELS; i++)
            en_count = en_count + EN_W'(mask_reg[i]);
    end

    assign need = NEED_W'(en_count) * NEED_W'(csfp_pkg::value_bytes(width_reg));
    assign full = (SUM_W'(fill) + SUM_W'(need)) > SUM_W'(CAP);

    // item sequencing
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ser_start  = 1'b0;
        case (state_reg)
            csfp_pkg::CS_IDLE:
            begin
                if (accept)
                begin
                    case (samples.opcode)
                        csfp_pkg::OP_FLUSH:
                        begin
                            ctrl.start_emit = (fill != '0);
                        end
                        csfp_pkg::OP_APPEND:
                        begin
                            ser_start      = 1'b1;
                            ctrl.count_set = 1'b1;
                            state_next     = csfp_pkg::CS_PACK;
                        end
                        default:
                        begin
                            state_next = csfp_pkg::CS_IDLE;
                        end
                    endcase
                end
            end
            csfp_pkg::CS_PACK:
            begin
                if (ser_done)
                    state_next = csfp_pkg::CS_DECIDE;
            end
            csfp_pkg::CS_DECIDE:
            begin
                ctrl.start_emit = !stream_reg || full;
                state_next      = csfp_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = csfp_pkg::CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg        <= '0;
            width_reg       <= csfp_pkg::WIDTH_MODE_RESET;
            stream_reg      <= 1'b0;
            client_code_reg <= '0;
            report_id_reg   <= '0;
            state_reg       <= csfp_pkg::CS_IDLE;
        end
        else
        begin
            mask_reg        <= mask_next;
            width_reg       <= width_next;
            stream_reg      <= stream_next;
            client_code_reg <= client_code_next;
            report_id_reg   <= report_id_next;
            state_reg       <= state_next;
        end
    end

    // byte serialiser
    csfp_byte_serialiser #(
        .CHANNELS (CHANNELS)
    ) u_serialiser (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ser_start),
        .values     (all_values[CHANNELS-1:0]),
        .mask       (mask_reg[CHANNELS-1:0]),
        .width_mode (width_reg),
        .byte_out   (ser_byte),
        .done       (ser_done)
    );

    // payload memory and frame sender
    csfp_frame_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_byte     (ser_byte),
        .ctrl        (ctrl),
        .report_id   (report_id_reg),
        .client_code (client_code_reg),
        .fill        (fill),
        .busy        (store_busy),
        .frames      (frames)
    );

endmodule

### tb/sv/channel_sample_frame_packer_tb.sv
// ----------------------------------------------------------------------------
// channel_sample_frame_packer_tb
// Self-checking bench for the channel sample frame packer.
// A short table of directed items comes first: reset defaults, byte and
// width extremes, width mode three, empty flushes, streaming full frames and
// a payload overrun after a mid-frame width change. Random register settings
// and sample sets follow, including a run of empty-mask sets in streaming
// mode. Every frame byte is checked against a local frame model.
// ----------------------------------------------------------------------------
module channel_sample_frame_packer_tb;

    localparam int FRAME_LEN     = 64;
    localparam int PAYLOAD_BYTES = FRAME_LEN - csfp_pkg::HEADER_BYTES;
    localparam int RAND_ITEMS    = 175;
    // long enough for a set to pack and pass its decision state
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 3000;
    localparam int DIR_ROWS      = 25;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef struct packed {
        logic        new_cfg;
        logic [7:0]  mask;
        logic [1:0]  wmode;
        logic        strm;
        logic [7:0]  app;
        logic [7:0]  rid;
        logic        op;
        logic [31:0] base;
        logic [31:0] step;
        logic        typed;
        logic [3:0]  n_exp;
        logic [63:0] exp_bytes;
    } dir_row_t;

    // cfg | mask | wmode | strm | app | rid | op | base | step | typed | n | bytes
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // reset defaults: empty flush, then a header-only frame
        '{1'b0, 8'h00, 2'd1, 1'b0, 8'h00, 8'h00, csfp_pkg::OP_FLUSH, 32'h0, 32'h0,
          1'b1, 4'd0, 64'h0},
        '{1'b0, 8'h00, 2'd1, 1'b0, 8'h00, 8'h00, csfp_pkg::OP_APPEND, 32'hFFFFFFFF,
          32'h0, 1'b1, 4'd3, 64'h000001_0000000000},
        // one channel at each width, lowest and highest channel
        '{1'b1, 8'h01, 2'd0, 1'b0, 8'h5A, 8'hA5, csfp_pkg::OP_APPEND, 32'h123456FF,
          32'h0, 1'b1, 4'd4, 64'hA55A01FF_00000000},
        '{1'b1, 8'h80, 2'd1, 1'b0, 8'hFF, 8'hFF, csfp_pkg::OP_APPEND, 32'h0000BEEF,
          32'h0, 1'b1, 4'd5, 64'hFFFF01BE_EF000000},
        '{1'b1, 8'h01, 2'd2, 1'b0, 8'h00, 8'h00, csfp_pkg::OP_APPEND, 32'hDEADBEEF,
          32'h0, 1'b1, 4'd7, 64'h000001DE_ADBEEF00},
        // width mode three packs four bytes
        '{1'b1, 8'h01, 2'd3, 1'b0, 8'h11, 8'h22, csfp_pkg::OP_APPEND, 32'h01020304,
          32'h0, 1'b1, 4'd7, 64'h22110101_02030400},
        // all channels, four bytes, value extremes
        '{1'b1, 8'hFF, 2'd2, 1'b0, 8'h3C, 8'hC3, csfp_pkg::OP_APPEND, 32'hFFFFFFFF,
          32'h0, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd2, 1'b0, 8'h3C, 8'hC3, csfp_pkg::OP_APPEND, 32'h00000000,
          32'h0, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd2, 1'b0, 8'h3C, 8'hC3, csfp_pkg::OP_APPEND, 32'h89ABCDEF,
          32'h11111111, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd2, 1'b0, 8'h3C, 8'hC3, csfp_pkg::OP_FLUSH, 32'hFFFFFFFF,
          32'h0, 1'b1, 4'd0, 64'h0},
        // streaming, frame full after the first set
        '{1'b1, 8'hFF, 2'd2, 1'b1, 8'h01, 8'h02, csfp_pkg::OP_APPEND, 32'hA5A5A5A5,
          32'h01010101, 1'b0, 4'd0, 64'h0},
        // streaming, partial frame flushed
        '{1'b1, 8'h0F, 2'd1, 1'b1, 8'h80, 8'h7F, csfp_pkg::OP_APPEND, 32'h00010203,
          32'h04040404, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'h0F, 2'd1, 1'b1, 8'h80, 8'h7F, csfp_pkg::OP_APPEND, 32'hF0E0D0C0,
          32'h00000101, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'h0F, 2'd1, 1'b1, 8'h80, 8'h7F, csfp_pkg::OP_FLUSH, 32'h0,
          32'h0, 1'b0, 4'd0, 64'h0},
        '{1'b1, 8'h55, 2'd0, 1'b1, 8'hAA, 8'h55, csfp_pkg::OP_APPEND, 32'h76543210,
          32'h10101010, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'h55, 2'd0, 1'b1, 8'hAA, 8'h55, csfp_pkg::OP_APPEND, 32'h89ABCDEF,
          32'h01010101, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'h55, 2'd0, 1'b1, 8'hAA, 8'h55, csfp_pkg::OP_FLUSH, 32'h0,
          32'h0, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'h55, 2'd0, 1'b1, 8'hAA, 8'h55, csfp_pkg::OP_FLUSH, 32'hFFFFFFFF,
          32'h0, 1'b1, 4'd0, 64'h0},
        // fill to 48 bytes one byte wide, then overrun at four bytes
        '{1'b1, 8'hFF, 2'd0, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'h00000001,
          32'h00000001, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd0, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'h00000010,
          32'h00000001, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd0, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'h00000020,
          32'h00000001, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd0, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'h00000030,
          32'h00000001, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd0, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'h00000040,
          32'h00000001, 1'b0, 4'd0, 64'h0},
        '{1'b0, 8'hFF, 2'd0, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'h00000050,
          32'h00000001, 1'b0, 4'd0, 64'h0},
        '{1'b1, 8'hFF, 2'd2, 1'b1, 8'hE7, 8'h7E, csfp_pkg::OP_APPEND, 32'hCAFEF00D,
          32'h01000001, 1'b0, 4'd0, 64'h0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    csfp_pkg::cfg_index_t cfg_index;
    logic [7:0]           cfg_data;

    csfp_in_if  samples_if ();
    csfp_out_if frames_if ();

    channel_sample_frame_packer #(
        .FRAME_BYTES (FRAME_LEN),
        .CHANNELS    (csfp_pkg::MAX_CHANNELS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .frames    (frames_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of registers and frame state
    logic [7:0] cur_mask;
    logic [1:0] cur_wmode;
    logic       cur_stream;
    logic [7:0] cur_app;
    logic [7:0] cur_rid;
    logic [7:0] pay_mem [PAYLOAD_BYTES];
    int         fill_cnt;
    logic [7:0] set_cnt;

    frame_byte_t frame_bytes_due [$];

    bit no_idle     = 1'b0;
    int byte_errors = 0;
    int bytes_seen  = 0;
    int frames_seen = 0;
    int sets_sent   = 0;
    int flushes_sent = 0;
    int settings_used = 0;
    int stuck_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // header plus filled payload, then the frame starts over
    function automatic void close_frame(ref frame_byte_t out_q[$]);
        int total;
        int k;
        logic [7:0] b;
        total = csfp_pkg::HEADER_BYTES + fill_cnt;
        for (k = 0; k < total; k++)
        begin
            if (k == csfp_pkg::HDR_REPORT_ID)
                b = cur_rid;
            else if (k == csfp_pkg::HDR_CLIENT_CODE)
                b = cur_app;
            else if (k == csfp_pkg::HDR_SET_COUNT)
                b = set_cnt;
            else
                b = pay_mem[k - csfp_pkg::HEADER_BYTES];
            out_q.push_back('{data: b, last: (k == total - 1)});
        end
        fill_cnt = 0;
        set_cnt  = 8'd0;
    endfunction

    // packs one set or flushes, returning the frame bytes that follow
    function automatic void pack_set(input logic op, input logic [7:0][31:0] chans,
                                     ref frame_byte_t out_q[$]);
        int width;
        int n_on;
        int k;
        int j;
        width = cur_wmode[1] ? 4 : (cur_wmode[0] ? 2 : 1);
        n_on  = $countones(cur_mask);
        if (op == csfp_pkg::OP_FLUSH)
        begin
            if (fill_cnt != 0)
                close_frame(out_q);
            return;
        end
        for (k = 0; k < csfp_pkg::MAX_CHANNELS; k++)
        begin
            if (cur_mask[k])
            begin
                // big-endian; bytes beyond the payload are dropped
                for (j = 0; j < width; j++)
                begin
                    if (fill_cnt < PAYLOAD_BYTES)
                    begin
                        pay_mem[fill_cnt] = chans[k][8*(width-1-j) +: 8];
                        fill_cnt++;
                    end
                end
            end
        end
        set_cnt = set_cnt + 8'd1;
        if (!cur_stream || fill_cnt + width * n_on > PAYLOAD_BYTES)
            close_frame(out_q);
    endfunction

    task automatic report_error(input string msg);
        byte_errors++;
        if (byte_errors <= 10)
            $display("mismatch: %s", msg);
    endtask

    // lower valid and wait for every due byte, optionally for the block to settle
    task automatic drain_frames(input bit settle);
        samples_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (frame_bytes_due.size() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] mask, input logic [1:0] wmode,
                                input logic strm, input logic [7:0] app,
                                input logic [7:0] rid);
        csfp_pkg::cfg_index_t idx [5];
        logic [7:0] val [5];
        int r;
        drain_frames(1'b1);
        idx = '{csfp_pkg::REG_CHANNEL_MASK, csfp_pkg::REG_WIDTH_MODE,
                csfp_pkg::REG_STREAMING_MODE, csfp_pkg::REG_CLIENT_CODE,
                csfp_pkg::REG_REPORT_ID};
        val = '{mask, {6'd0, wmode}, {7'd0, strm}, app, rid};
        for (r = 0; r < 5; r++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= val[r];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        cur_mask   = mask;
        cur_wmode  = wmode;
        cur_stream = strm;
        cur_app    = app;
        cur_rid    = rid;
        settings_used++;
    endtask

    // offers one item; expected bytes come from the table when typed in
    task automatic send_item(input logic op, input logic [7:0][31:0] chans,
                             input logic typed, input int n_exp,
                             input logic [63:0] exp_bytes);
        frame_byte_t res [$];
        bit taken;
        int k;
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid        <= 1'b1;
        samples_if.opcode       <= op;
        samples_if.chan_value_0 <= chans[0];
        samples_if.chan_value_1 <= chans[1];
        samples_if.chan_value_2 <= chans[2];
        samples_if.chan_value_3 <= chans[3];
        samples_if.chan_value_4 <= chans[4];
        samples_if.chan_value_5 <= chans[5];
        samples_if.chan_value_6 <= chans[6];
        samples_if.chan_value_7 <= chans[7];
        // ready is stable between the falling edge and the next rising edge
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = samples_if.ready;
            @(posedge clk);
        end
        pack_set(op, chans, res);
        if (typed)
        begin
            for (k = 0; k < n_exp; k++)
                frame_bytes_due.push_back('{data: exp_bytes[63-8*k -: 8],
                                            last: (k == n_exp - 1)});
        end
        else
        begin
            for (k = 0; k < res.size(); k++)
                frame_bytes_due.push_back(res[k]);
        end
        if (op == csfp_pkg::OP_FLUSH)
            flushes_sent++;
        else
            sets_sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: random stalls, every accepted byte checked in order
    initial
    begin
        frame_byte_t got;
        frame_byte_t want;
        bit take;
        frames_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            take     = rst_n && frames_if.valid && frames_if.ready;
            got.data = frames_if.frame_byte;
            got.last = frames_if.frame_last;
            @(posedge clk);
            if (take)
            begin
                bytes_seen++;
                if (got.last === 1'b1)
                    frames_seen++;
                if (frame_bytes_due.size() == 0)
                    report_error($sformatf("unexpected byte %02h last %0b",
                                           got.data, got.last));
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (got.data !== want.data || got.last !== want.last)
                        report_error($sformatf(
                            "byte %0d: expected %02h last %0b, got %02h last %0b",
                            bytes_seen, want.data, want.last, got.data, got.last));
                end
            end
            frames_if.ready <= no_idle || ($urandom_range(0, 99) >= 38);
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin
        wait (rst_n === 1'b1);
        while (stuck_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((samples_if.valid && samples_if.ready) ||
                (frames_if.valid && frames_if.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d bytes still due",
                 STALL_LIMIT, frame_bytes_due.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        dir_row_t           row;
        logic [7:0][31:0]   chans;
        logic               op;
        logic [7:0]         mask;
        logic               strm;
        int                 r;
        int                 c;
        int                 k;
        int                 n;
        int                 phase;
        int                 rand_items;

        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_index               <= csfp_pkg::REG_CHANNEL_MASK;
        cfg_data                <= 8'h00;
        samples_if.valid        <= 1'b0;
        samples_if.opcode       <= csfp_pkg::OP_APPEND;
        samples_if.chan_value_0 <= '0;
        samples_if.chan_value_1 <= '0;
        samples_if.chan_value_2 <= '0;
        samples_if.chan_value_3 <= '0;
        samples_if.chan_value_4 <= '0;
        samples_if.chan_value_5 <= '0;
        samples_if.chan_value_6 <= '0;
        samples_if.chan_value_7 <= '0;

        // register defaults and an empty frame after reset
        cur_mask   = 8'h00;
        cur_wmode  = csfp_pkg::WIDTH_MODE_RESET;
        cur_stream = 1'b0;
        cur_app    = 8'h00;
        cur_rid    = 8'h00;
        fill_cnt   = 0;
        set_cnt    = 8'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
        begin
            row = DIR_TAB[r];
            if (row.new_cfg)
                apply_config(row.mask, row.wmode, row.strm, row.app, row.rid);
            for (c = 0; c < csfp_pkg::MAX_CHANNELS; c++)
                chans[c] = row.base + 32'(c) * row.step;
            send_item(row.op, chans, row.typed, int'(row.n_exp), row.exp_bytes);
        end

        // random settings; phase 2 runs empty-mask sets in streaming mode,
        // phase 4 runs with no idling on either side
        phase      = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            mask = (phase == 2) ? 8'h00 : pick_byte();
            if (phase == 3)
                mask = mask | 8'h01;
            strm = (phase == 2) ? 1'b1 : ($urandom_range(0, 99) < 70);
            no_idle = (phase == 4);
            apply_config(mask, 2'($urandom_range(0, 3)), strm, pick_byte(), pick_byte());
            n = $urandom_range(12, 28);
            for (k = 0; k < n; k++)
            begin
                // sender holds off until every due byte has come
                if ($urandom_range(0, 24) == 0 || (phase == 1 && k == 4))
                    drain_frames(1'b0);
                op = ($urandom_range(0, 99) < (strm ? 12 : 5)) ?
                     csfp_pkg::OP_FLUSH : csfp_pkg::OP_APPEND;
                for (c = 0; c < csfp_pkg::MAX_CHANNELS; c++)
                    chans[c] = pick_word();
                send_item(op, chans, 1'b0, 0, 64'h0);
                rand_items++;
            end
            phase++;
        end
        no_idle = 1'b0;

        // wind down
        drain_frames(1'b1);
        if (frame_bytes_due.size() != 0)
            report_error($sformatf("%0d bytes never arrived", frame_bytes_due.size()));

        $display("run: %0d sample sets and %0d flushes over %0d register settings",
                 sets_sent, flushes_sent, settings_used);
        $display("run: %0d frames, %0d bytes compared, %0d errors",
                 frames_seen, bytes_seen, byte_errors);
        if (byte_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
